@@ hdl/slcd_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; used by slcd_parser, slcd_out_reg and the top level.
package slcd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'h41;   // 'A'
    localparam logic [7:0]  SYNC_SECOND = 8'h34;   // '4'
    localparam logic [15:0] LEN_MASK    = 16'hffff;

    typedef enum logic [3:0] {
        PH_HUNT     = 4'd0,
        PH_SYNC2    = 4'd1,
        PH_CSUM     = 4'd2,
        PH_LEN_LO   = 4'd3,
        PH_LEN_HI   = 4'd4,
        PH_INV_LO   = 4'd5,
        PH_INV_HI   = 4'd6,
        PH_SECS     = 4'd7,
        PH_FRAC_LO  = 4'd8,
        PH_FRAC_HI  = 4'd9,
        PH_SEQ      = 4'd10,
        PH_PAYLOAD  = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last_byte;
        logic        checksum_good;
        logic [7:0]  time_seconds;
        logic [15:0] time_fraction;
        logic [7:0]  sequence_number;
    } result_t;

endpackage

@@ hdl/slcd_in_reg.sv @@
// Input register stage: holds one received byte until the parser takes it.
// Depends on nothing but the clock and reset.
module slcd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;

    assign s_ready    = !valid_reg || byte_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (byte_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ hdl/slcd_parser.sv @@
// Frame parser: phase machine, header holds and payload count/sum.
// Depends on slcd_pkg.
module slcd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,       // commit this byte
    input  logic [7:0]          rx_byte,
    output logic                emit,       // this byte yields a result
    output slcd_pkg::result_t   result
);

    slcd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  expected_sum_reg, expected_sum_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  seconds_reg, seconds_next;
    logic [15:0] fraction_reg, fraction_next;
    logic [7:0]  sequence_reg, sequence_next;

    logic [15:0] word;
    logic [7:0]  sum;
    logic [16:0] count_plus;
    logic        last;

    assign word       = {rx_byte, low_byte_reg};
    assign sum        = running_sum_reg + rx_byte;
    assign count_plus = {1'b0, payload_count_reg} + 17'd1;
    assign last       = count_plus >= {1'b0, frame_length_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= slcd_pkg::PH_HUNT;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            expected_sum_reg  <= expected_sum_next;
            frame_length_reg  <= frame_length_next;
            low_byte_reg      <= low_byte_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
            seconds_reg       <= seconds_next;
            fraction_reg      <= fraction_next;
            sequence_reg      <= sequence_next;
        end
    end

    always_comb begin
        phase_next         = slcd_pkg::PH_HUNT;
        expected_sum_next  = expected_sum_reg;
        frame_length_next  = frame_length_reg;
        low_byte_next      = low_byte_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;
        seconds_next       = seconds_reg;
        fraction_next      = fraction_reg;
        sequence_next      = sequence_reg;
        emit               = 1'b0;

        unique case (phase_reg)
            slcd_pkg::PH_SYNC2: begin
                phase_next = (rx_byte == slcd_pkg::SYNC_SECOND) ? slcd_pkg::PH_CSUM
                                                                : slcd_pkg::PH_HUNT;
            end
            slcd_pkg::PH_CSUM: begin
                expected_sum_next = rx_byte;
                phase_next        = slcd_pkg::PH_LEN_LO;
            end
            slcd_pkg::PH_LEN_LO: begin
                low_byte_next = rx_byte;
                phase_next    = slcd_pkg::PH_LEN_HI;
            end
            slcd_pkg::PH_LEN_HI: begin
                frame_length_next = word;
                phase_next        = slcd_pkg::PH_INV_LO;
            end
            slcd_pkg::PH_INV_LO: begin
                low_byte_next = rx_byte;
                phase_next    = slcd_pkg::PH_INV_HI;
            end
            slcd_pkg::PH_INV_HI: begin
                // inverse must match and a zero length is refused
                if (word != (slcd_pkg::LEN_MASK ^ frame_length_reg) ||
                    frame_length_reg == 16'd0) begin
                    phase_next = slcd_pkg::PH_HUNT;
                end else begin
                    phase_next = slcd_pkg::PH_SECS;
                end
            end
            slcd_pkg::PH_SECS: begin
                seconds_next = rx_byte;
                phase_next   = slcd_pkg::PH_FRAC_LO;
            end
            slcd_pkg::PH_FRAC_LO: begin
                low_byte_next = rx_byte;
                phase_next    = slcd_pkg::PH_FRAC_HI;
            end
            slcd_pkg::PH_FRAC_HI: begin
                fraction_next = word;
                phase_next    = slcd_pkg::PH_SEQ;
            end
            slcd_pkg::PH_SEQ: begin
                sequence_next      = rx_byte;
                payload_count_next = 16'd0;
                running_sum_next   = 8'd0;
                phase_next         = slcd_pkg::PH_PAYLOAD;
            end
            slcd_pkg::PH_PAYLOAD: begin
                emit             = 1'b1;
                running_sum_next = sum;
                if (last) begin
                    phase_next = slcd_pkg::PH_HUNT;
                end else begin
                    payload_count_next = count_plus[15:0];
                    phase_next         = slcd_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                phase_next = (rx_byte == slcd_pkg::SYNC_FIRST) ? slcd_pkg::PH_SYNC2
                                                               : slcd_pkg::PH_HUNT;
            end
        endcase
    end

    always_comb begin
        result.payload_byte    = rx_byte;
        result.byte_index      = payload_count_reg;
        result.last_byte       = last;
        result.checksum_good   = last && (sum == expected_sum_reg);
        result.time_seconds    = seconds_reg;
        result.time_fraction   = fraction_reg;
        result.sequence_number = sequence_reg;
    end

endmodule

@@ hdl/slcd_out_reg.sv @@
// Result register: holds one result beat until the sink takes it.
// Depends on slcd_pkg.
module slcd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  slcd_pkg::result_t load_data,
    output logic              free,      // may load this cycle
    output logic              m_valid,
    input  logic              m_ready,
    output slcd_pkg::result_t m_data
);

    logic              valid_reg, valid_next;
    slcd_pkg::result_t data_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ hdl/sync_length_checksum_deframer.sv @@
// Top level of the sync/length/checksum deframer.
// Depends on slcd_pkg, slcd_in_reg, slcd_parser and slcd_out_reg.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_rx_byte
//  m_       out        m_valid / m_ready  m_payload_byte .. m_sequence_number
//
// One byte per cycle while the result register does not stall; a payload byte's
// beat goes from the input register through the parser into the result register.
// Synchronous active-low reset puts the parser in the hunt and empties both stages.
// Header bytes never stall; a payload byte waits in the input register only
// while the result register is full and not being taken.
module sync_length_checksum_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_byte_index,
    output logic        m_last_byte,
    output logic        m_checksum_good,
    output logic [7:0]  m_time_seconds,
    output logic [15:0] m_time_fraction,
    output logic [7:0]  m_sequence_number
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              step;
    logic              emit;
    logic              out_free;
    slcd_pkg::result_t result;
    slcd_pkg::result_t m_data;

    // a byte that yields no beat never waits for the sink
    assign step = byte_valid && (!emit || out_free);

    slcd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (step)
    );

    slcd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (byte_data),
        .emit    (emit),
        .result  (result)
    );

    slcd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && emit),
        .load_data (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_payload_byte    = m_data.payload_byte;
    assign m_byte_index      = m_data.byte_index;
    assign m_last_byte       = m_data.last_byte;
    assign m_checksum_good   = m_data.checksum_good;
    assign m_time_seconds    = m_data.time_seconds;
    assign m_time_fraction   = m_data.time_fraction;
    assign m_sequence_number = m_data.sequence_number;

endmodule
